>>> sv/smf_pkg.sv
`timescale 1ns / 1ps
package smf_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int LEN_W     = WIN_IDX_W + 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int PAT_W      = 8 * WIN_DEPTH;

    localparam logic [7:0] MASK_CHAR = 8'h2A;

    localparam logic [1:0] REG_LEN    = 2'd0;
    localparam logic [1:0] REG_PAT_LO = 2'd1;
    localparam logic [1:0] REG_PAT_HI = 2'd2;

    typedef struct packed {
        logic [7:0] chr;
        logic       masked;
        logic       last;
    } t_entry;

    // clamp the programmed length into 1..WIN_DEPTH
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] v;
        v = len;
        if (len == '0) begin
            v = LEN_W'(1);
        end else if (len > LEN_W'(WIN_DEPTH)) begin
            v = LEN_W'(WIN_DEPTH);
        end
        return v;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                            input logic [WIN_IDX_W-1:0] idx);
        return pat[8*idx +: 8];
    endfunction

endpackage

>>> sv/smf_front.sv
`timescale 1ns / 1ps
module smf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [7:0]                   i_char,
    input  logic                         i_last,
    output logic                         o_stall,
    input  logic [smf_pkg::LEN_W-1:0]    i_len,
    input  logic [smf_pkg::PAT_W-1:0]    i_pattern,
    input  logic                         i_q_full,
    output logic                         o_push,
    output smf_pkg::t_entry              o_push_data
);
    import smf_pkg::*;

    logic [7:0]           r_char [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] r_mask;
    logic [WIN_IDX_W-1:0] r_fill;
    logic                 r_drain;
    logic                 r_drain_last;

    logic [7:0]           w_char [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] w_mask;
    logic [WIN_DEPTH-1:0] m_mask;
    logic [LEN_W-1:0]     cnt;
    logic                 hit;
    logic                 accept;
    logic                 drain_go;
    logic                 push_acc;
    logic [WIN_IDX_W-1:0] fill_acc;
    logic [WIN_IDX_W-1:0] fill_drn;
    logic [WIN_IDX_W-1:0] n_fill;
    logic                 n_drain;
    logic                 n_drain_last;

    assign o_stall  = r_drain | i_q_full;
    assign accept   = i_valid & ~o_stall;
    assign drain_go = r_drain & ~i_q_full;
    assign cnt      = {1'b0, r_fill} + LEN_W'(1);

    // window after the new character enters at the newest slot
    always_comb begin
        w_char[0] = i_char;
        w_mask[0] = 1'b0;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            w_char[k] = r_char[k-1];
            w_mask[k] = r_mask[k-1];
        end
    end

    // slot i holds the i-th newest character, matched against pattern[len-1-i]
    always_comb begin : p_match
        logic [WIN_IDX_W-1:0] v_pidx;
        v_pidx = '0;
        hit    = (cnt >= i_len);
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (LEN_W'(i) < i_len) begin
                v_pidx = WIN_IDX_W'(i_len - LEN_W'(i) - LEN_W'(1));
                if (w_mask[i] || (w_char[i] != pat_byte(i_pattern, v_pidx))) begin
                    hit = 1'b0;
                end
            end
        end
        for (int i = 0; i < WIN_DEPTH; i++) begin
            m_mask[i] = w_mask[i] | (hit & (LEN_W'(i) < i_len));
        end
    end

    assign push_acc = i_last | (cnt >= i_len);
    assign fill_acc = push_acc ? r_fill : cnt[WIN_IDX_W-1:0];
    assign fill_drn = r_fill - WIN_IDX_W'(1);

    always_comb begin
        o_push       = 1'b0;
        o_push_data  = '0;
        n_fill       = r_fill;
        n_drain      = r_drain;
        n_drain_last = r_drain_last;
        if (accept) begin
            o_push             = push_acc;
            o_push_data.chr    = w_char[r_fill];
            o_push_data.masked = m_mask[r_fill];
            o_push_data.last   = i_last & (cnt == LEN_W'(1));
            n_fill             = fill_acc;
            n_drain_last       = i_last;
            n_drain            = i_last ? (fill_acc != '0)
                                        : ({1'b0, fill_acc} >= i_len);
        end else if (drain_go) begin
            // flush the oldest surplus entry
            o_push             = 1'b1;
            o_push_data.chr    = r_char[fill_drn];
            o_push_data.masked = r_mask[fill_drn];
            o_push_data.last   = r_drain_last & (r_fill == WIN_IDX_W'(1));
            n_fill             = fill_drn;
            n_drain            = r_drain_last ? (fill_drn != '0)
                                              : ({1'b0, fill_drn} >= i_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_fill       <= '0;
            r_drain      <= 1'b0;
            r_drain_last <= 1'b0;
        end else begin
            if (accept) begin
                r_mask <= m_mask;
            end
            r_fill       <= n_fill;
            r_drain      <= n_drain;
            r_drain_last <= n_drain_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_char[k] <= w_char[k];
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("push into a full queue");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_drain) && r_drain_last) |-> (r_fill == '0))
        else $error("window not empty after final flush");

endmodule

>>> sv/smf_queue.sv
`timescale 1ns / 1ps
module smf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smf_pkg::t_entry i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_pop_valid,
    output smf_pkg::t_entry o_pop_data
);
    import smf_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd];
    assign do_push     = i_push & ~o_full;
    assign do_pop      = i_pop & o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |=> (r_count == QCNT_W'(QDEPTH)) || !$past(i_pop))
        else $error("queue count moved on push into full queue");

endmodule

>>> sv/smf_back.sv
`timescale 1ns / 1ps
module smf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  smf_pkg::t_entry i_q_data,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_char,
    output logic            o_masked,
    output logic            o_last
);
    import smf_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_masked;
    logic       r_last;

    assign o_pop = i_q_valid & (~r_valid | ~i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_pop | (r_valid & i_stall);
        end
    end

    // substitute the mask character as the entry leaves
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char   <= i_q_data.masked ? MASK_CHAR : i_q_data.chr;
            r_masked <= i_q_data.masked;
            r_last   <= i_q_data.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_char   = r_char;
    assign o_masked = r_masked;
    assign o_last   = r_last;

endmodule

>>> sv/substring_mask_filter_core.sv
`timescale 1ns / 1ps
// Streaming substring masking filter. Text enters one character per transfer
// and leaves in the same order, with every left-to-right, non-overlapping
// occurrence of the programmed pattern (1 to 16 characters) replaced by '*'
// and flagged on o_out_masked; characters already masked never join a later
// match. A character is held in a 16-entry window until no further match can
// include it, so output trails input by pattern_length - 1 characters plus
// the queue and output register. Sustained rate is one character per cycle
// while input is not stalled by a flush or a full queue. A transfer with
// i_text_last flushes the whole window, one entry per cycle while the queue
// has room, through the single write port of the output queue; the oldest
// entry goes out with the last transfer, and input is stalled until the rest
// has drained. A pattern_length made shorter in mid text stalls input after
// the next character until the surplus window entries have drained. Program
// pattern_length at byte address 0, pattern characters 0..7 at 8 and 8..15 at
// 16 (character i in bits 8i+7..8i), only while the block is idle.
module substring_mask_filter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [smf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [smf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // text input
    input  logic                               i_text_valid,
    output logic                               o_text_stall,
    input  logic [7:0]                         i_text_char,
    input  logic                               i_text_last,
    // filtered output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_out_char,
    output logic                               o_out_masked,
    output logic                               o_out_last
);
    import smf_pkg::*;

    logic [LEN_W-1:0]      r_len;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;

    logic   q_full;
    logic   q_push;
    t_entry q_push_data;
    logic   q_pop;
    logic   q_valid;
    t_entry q_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:3];

    // register file: take the write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LEN:    r_len    <= pwdata[LEN_W-1:0];
                REG_PAT_LO: r_pat_lo <= pwdata;
                REG_PAT_HI: r_pat_hi <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LEN:    prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, r_len};
            REG_PAT_LO: prdata = r_pat_lo;
            REG_PAT_HI: prdata = r_pat_hi;
            default:    prdata = '0;
        endcase
    end

    // front: window, match and emission order
    smf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_text_valid),
        .i_char      (i_text_char),
        .i_last      (i_text_last),
        .o_stall     (o_text_stall),
        .i_len       (eff_len(r_len)),
        .i_pattern   ({r_pat_hi, r_pat_lo}),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // decouple the window from the output stall
    smf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_valid (q_valid),
        .o_pop_data  (q_data)
    );

    // back: mask substitution and output register
    smf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_char    (o_out_char),
        .o_masked  (o_out_masked),
        .o_last    (o_out_last)
    );

endmodule

>>> verif/tb_substring_mask_filter_core.sv
`timescale 1ns / 1ps
module tb_substring_mask_filter_core;
    import smf_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 64;     // window fill plus queue and output register
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 80;     // long receiver hold-off, fills queue and window
    localparam int SUBPHASES        = 3;
    localparam int TEXT_ITEMS       = 22;
    localparam int SHOWN_MISMATCHES = 10;

    // one text transfer waiting to be offered
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } t_text_xfer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_text_valid;
    logic                  o_text_stall;
    logic [7:0]            i_text_char;
    logic                  i_text_last;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_out_char;
    logic                  o_out_masked;
    logic                  o_out_last;

    substring_mask_filter_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_text_valid (i_text_valid),
        .o_text_stall (o_text_stall),
        .i_text_char  (i_text_char),
        .i_text_last  (i_text_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_out_masked (o_out_masked),
        .o_out_last   (o_out_last)
    );

    // Mirror of the programmed registers, kept in step with every write.
    logic [4:0]  pat_len_reg = 5'd1;
    logic [63:0] pat_lo_reg  = '0;
    logic [63:0] pat_hi_reg  = '0;

    // Mirror of the match window: oldest entry at index 0.
    logic [7:0]  win_chr [WIN_DEPTH];
    bit          win_msk [WIN_DEPTH];
    int unsigned win_fill = 0;

    t_entry      masked_out_q[$];   // filtered characters still owed by the block
    t_text_xfer  pending[$];        // text not yet offered
    int unsigned queued_cnt = 0;
    int unsigned taken_cnt  = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_cnt  = 0;

    bit text_fire;                  // input transfer at the last rising edge
    int send_idle_pct = 12;
    int recv_idle_pct = 57;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Masking predictor
    // ------------------------------------------------------------------

    // Clamp the programmed length: zero acts as one, anything past the
    // window depth acts as the full depth.
    function automatic int unsigned active_len();
        if (pat_len_reg == '0) return 1;
        if (pat_len_reg > WIN_DEPTH) return WIN_DEPTH;
        return pat_len_reg;
    endfunction

    // Pop the oldest window entry into the list of owed output characters.
    function automatic void shift_out_oldest(input bit fin);
        t_entry e;
        e.chr    = win_msk[0] ? MASK_CHAR : win_chr[0];
        e.masked = win_msk[0];
        e.last   = fin;
        masked_out_q.push_back(e);
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_chr[i] = win_chr[i+1];
            win_msk[i] = win_msk[i+1];
        end
        win_msk[WIN_DEPTH-1] = 1'b0;
        win_fill--;
    endfunction

    // Append one text character, mask a fresh match over the newest entries,
    // then release whatever can no longer join a match (everything on last).
    function automatic void mask_text_char(input logic [7:0] ch, input logic fin);
        int unsigned n;
        int unsigned base;
        bit          hit;
        logic [127:0] pat;
        n   = active_len();
        pat = {pat_hi_reg, pat_lo_reg};
        if (win_fill >= WIN_DEPTH) shift_out_oldest(1'b0);
        win_chr[win_fill] = ch;
        win_msk[win_fill] = 1'b0;
        win_fill++;
        if (win_fill >= n) begin
            base = win_fill - n;
            hit  = 1'b1;
            // a masked entry never joins a later match
            for (int i = 0; i < n; i++) begin
                if (win_msk[base+i] || win_chr[base+i] != pat[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < n; i++) win_msk[base+i] = 1'b1;
            end
        end
        if (fin) begin
            while (win_fill > 0) shift_out_oldest(win_fill == 1);
        end else begin
            // a shortened length can release several surplus entries here
            while (win_fill >= n) shift_out_oldest(1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every input transfer, check every output transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : out_check
        t_entry want;
        text_fire = i_rst_n && i_text_valid && !o_text_stall;
        if (text_fire) begin
            mask_text_char(i_text_char, i_text_last);
            taken_cnt++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (masked_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display({"cycle %0d: output transfer with none owed: ",
                              "char %h masked %b last %b"},
                             cycle_cnt, o_out_char, o_out_masked, o_out_last);
            end else begin
                want = masked_out_q.pop_front();
                if (o_out_char !== want.chr || o_out_masked !== want.masked ||
                    o_out_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display({"cycle %0d: expected char %h masked %b last %b, ",
                                  "got char %h masked %b last %b"},
                                 cycle_cnt, want.chr, want.masked, want.last,
                                 o_out_char, o_out_masked, o_out_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued text at the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : text_driver
        t_text_xfer nxt;
        if (!i_rst_n) begin
            i_text_valid <= 1'b0;
        end else if (!i_text_valid || text_fire) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending.pop_front();
                i_text_valid <= 1'b1;
                i_text_char  <= nxt.chr;
                i_text_last  <= nxt.last;
            end else begin
                i_text_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a long counted hold-off when requested.
    always @(negedge i_clk) begin : out_receiver
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** substring_mask_filter_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_text(input logic [7:0] c, input logic lst);
        t_text_xfer t;
        t.chr  = c;
        t.last = lst;
        pending.push_back(t);
        queued_cnt++;
    endtask

    // Write one register through a setup and an access phase, track it.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_LEN:    pat_len_reg = val[4:0];
            REG_PAT_LO: pat_lo_reg  = val;
            REG_PAT_HI: pat_hi_reg  = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_filter(input logic [4:0] len, input logic [127:0] pat);
        write_reg(REG_LEN, 64'(len));
        write_reg(REG_PAT_LO, pat[63:0]);
        write_reg(REG_PAT_HI, pat[127:64]);
    endtask

    // Wait for every queued character to be taken and every owed result to
    // arrive, then let the window settle before anything is reprogrammed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (taken_cnt != queued_cnt || masked_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly small lengths, some long ones, and the out-of-range values.
    task automatic program_random();
        logic [127:0] pat;
        logic [4:0]   len;
        int           r;
        r = $urandom_range(99);
        if (r < 65)      len = 5'($urandom_range(5, 1));
        else if (r < 85) len = 5'($urandom_range(16, 6));
        else if (r < 90) len = 5'd0;
        else if (r < 95) len = 5'd31;
        else             len = 5'($urandom_range(30, 17));
        for (int i = 0; i < WIN_DEPTH; i++) begin
            r = $urandom_range(99);
            if (r < 40)      pat[8*i +: 8] = "a";
            else if (r < 65) pat[8*i +: 8] = "b";
            else if (r < 80) pat[8*i +: 8] = MASK_CHAR;
            else             pat[8*i +: 8] = 8'($urandom_range(255));
        end
        program_filter(len, pat);
    endtask

    // Text built around the live pattern: whole copies, broken copies and
    // characters drawn from it, with some noise and scattered text ends.
    task automatic queue_random_text(input int n, input bit close);
        logic [127:0] pat;
        logic [7:0]   c;
        int           len;
        int           k;
        int           pos;
        int           idx;
        int           r;
        len = active_len();
        pat = {pat_hi_reg, pat_lo_reg};
        k   = 0;
        while (k < n) begin
            if ($urandom_range(3) == 0) begin
                // whole copy, one in four with a corrupted character
                pos = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : len;
                for (int i = 0; i < len; i++) begin
                    c = pat[8*i +: 8];
                    if (i == pos) c = ~c;
                    push_text(c, $urandom_range(15) == 0);
                    k++;
                end
            end else begin
                r   = $urandom_range(99);
                idx = $urandom_range(len - 1);
                if (r < 55)      c = pat[8*idx +: 8];
                else if (r < 70) c = MASK_CHAR;
                else if (r < 80) c = "a";
                else             c = 8'($urandom_range(255));
                push_text(c, $urandom_range(11) == 0);
                k++;
            end
        end
        if (close) push_text(8'($urandom_range(255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [127:0] pat;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_text_valid = 1'b0;
        i_text_char  = '0;
        i_text_last  = 1'b0;
        i_out_stall  = 1'b0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_chr[i] = '0;
            win_msk[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pattern is a single zero byte: zero characters get masked.
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(MASK_CHAR, 1'b0);
        push_text(8'h00, 1'b1);
        wait_drained();

        // Length 31 clamps to 16; a full-length match closes the text, so the
        // final transfer flushes all sixteen masked characters.
        for (int i = 0; i < WIN_DEPTH; i++) pat[8*i +: 8] = 8'h41 + 8'(i);
        program_filter(5'd31, pat);
        for (int i = 0; i < WIN_DEPTH; i++) push_text(pat[8*i +: 8], i == WIN_DEPTH - 1);
        wait_drained();

        // Pattern of two stars: the third star must not pair with a masked one.
        // Leave the text open so the window still holds it.
        program_filter(5'd2, {WIN_DEPTH{MASK_CHAR}});
        repeat (3) push_text(MASK_CHAR, 1'b0);
        wait_drained();

        // Shorten mid text (zero acts as one): the surplus star leaves with 'y'.
        program_filter(5'd0, {WIN_DEPTH{MASK_CHAR}});
        push_text("y", 1'b0);
        wait_drained();

        // Random part under three idling patterns.
        for (int mode = 0; mode < 3; mode++) begin
            @(posedge i_clk);
            case (mode)
                0: begin send_idle_pct = 12; recv_idle_pct = 57; end
                1: begin send_idle_pct = 57; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int sp = 0; sp < SUBPHASES; sp++) begin
                program_random();
                if (mode == 2 && sp == 0) begin
                    // hold off the receiver while the sender keeps going
                    @(posedge i_clk);
                    hold_req = 1'b1;
                end
                queue_random_text(TEXT_ITEMS, $urandom_range(1));
                wait_drained();
            end
        end

        if (mismatches == 0 && masked_out_q.size() == 0) begin
            $display("** substring_mask_filter_core: PASSED **");
        end else begin
            $display("** substring_mask_filter_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
sv/smf_pkg.sv
sv/smf_front.sv
sv/smf_queue.sv
sv/smf_back.sv
sv/substring_mask_filter_core.sv
verif/tb_substring_mask_filter_core.sv
